>>> sv/pedal_hold_cruise_controller_macros.svh
// assertion macros used by the checker file
`ifndef PEDAL_HOLD_CRUISE_CONTROLLER_MACROS_SVH
`define PEDAL_HOLD_CRUISE_CONTROLLER_MACROS_SVH

// property checked on every clock edge outside reset
`define PHCC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define PHCC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/phcc_pkg.sv
package phcc_pkg;

	// button codes
	typedef enum logic [2:0] {
		BTN_NONE     = 3'd0,
		BTN_UP       = 3'd1,
		BTN_VOL_UP   = 3'd2,
		BTN_VOL_DOWN = 3'd3,
		BTN_INFO     = 3'd4,
		BTN_SOURCE   = 3'd5,
		BTN_DOWN     = 3'd6
	} button_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_LIMIT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_FACTOR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DELAY_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_DIVIDER  = 3'd4;

	// configuration reset values
	localparam logic [9:0]  PEDAL_MIN_RST       = 10'd100;
	localparam logic [13:0] RPM_LIMIT_RST       = 14'd4000;
	localparam logic [15:0] STEP_FACTOR_RST     = 16'd655;
	localparam logic [15:0] SWITCH_DELAY_MS_RST = 16'd1000;
	localparam logic [7:0]  BUTTON_DIVIDER_RST  = 8'd3;

	localparam logic [9:0] HOLD_MAX = 10'd1023;

	typedef struct packed {
		logic [2:0]  button;
		logic [9:0]  pedal_a;
		logic [9:0]  pedal_b;
		logic        pedal_plugged;
		logic        car_linked;
		logic        braking;
		logic [13:0] engine_rpm;
		logic [31:0] now_ms;
	} tick_item_t;

	typedef struct packed {
		logic       switch_on;
		logic [9:0] duty_a;
		logic [9:0] duty_b;
		logic       duty_changed;
		logic       cruise_led;
	} result_item_t;

	typedef struct packed {
		logic [9:0]  pedal_min;
		logic [13:0] rpm_limit;
		logic [15:0] step_factor;
		logic [15:0] switch_delay_ms;
		logic [7:0]  button_divider;
	} cfg_t;

	typedef struct packed {
		logic        cruise_on;
		logic        capture_pending;
		logic [9:0]  hold_a;
		logic [9:0]  hold_b;
		logic [7:0]  tick_count;
		logic        link_was_up;
		logic        last_enable_seen;
		logic [31:0] toggle_time;
		logic        switch_level;
		logic [9:0]  last_duty_a;
		logic [9:0]  last_duty_b;
	} state_t;

endpackage

>>> sv/phcc_ifs.sv
// tick channel
interface phcc_tick_if;
	logic                  valid;
	logic                  ready;
	phcc_pkg::tick_item_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// result channel
interface phcc_result_if;
	logic                    valid;
	logic                    ready;
	phcc_pkg::result_item_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// configuration write channel
interface phcc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [phcc_pkg::CFG_IDX_W-1:0]     index;
	logic [phcc_pkg::CFG_DATA_W-1:0]    wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

>>> sv/pedal_hold_cruise_controller.sv
// pedal-hold cruise controller, one control tick per transaction
// a tick passes through the input register, the step logic and the result register
// throughput: one tick per cycle while results are taken, set by the single-pass step logic
// between the two registers; a stalled result holds the tick in the input register,
// ticks stop once both registers are full
// reset (arst_n low, asynchronous): both stages empty, registers at their defaults, cruise off
module pedal_hold_cruise_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	phcc_tick_if.sink             tick,
	phcc_result_if.source         result,
	phcc_cfg_if.sink              cfg
);

	phcc_pkg::cfg_t         cfg_cur;
	phcc_pkg::state_t       state_q;
	phcc_pkg::state_t       state_nxt;
	phcc_pkg::result_item_t res_nxt;
	phcc_pkg::tick_item_t   item_s1;
	logic                   valid_s1;
	phcc_pkg::result_item_t res_q;
	logic                   res_valid_q;
	logic                   advance;

	// configuration registers
	assign cfg.ready = 1'b1;

	phcc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.wdata),
		.cfg      (cfg_cur)
	);

	// handshake control
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= tick.data;
		end
	end

	// step logic
	phcc_step_logic u_step_logic (
		.cfg  (cfg_cur),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cruise_on        <= 1'b0;
			state_q.capture_pending  <= 1'b0;
			state_q.hold_a           <= 10'd0;
			state_q.hold_b           <= 10'd0;
			state_q.tick_count       <= 8'd0;
			state_q.link_was_up      <= 1'b0;
			state_q.last_enable_seen <= 1'b1;
			state_q.toggle_time      <= 32'd0;
			state_q.switch_level     <= 1'b0;
			state_q.last_duty_a      <= 10'd1;
			state_q.last_duty_b      <= 10'd1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

>>> sv/phcc_cfg_regs.sv
module phcc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [phcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [phcc_pkg::CFG_DATA_W-1:0] wr_data,
	output phcc_pkg::cfg_t                  cfg
);

	phcc_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pedal_min       <= phcc_pkg::PEDAL_MIN_RST;
			cfg_q.rpm_limit       <= phcc_pkg::RPM_LIMIT_RST;
			cfg_q.step_factor     <= phcc_pkg::STEP_FACTOR_RST;
			cfg_q.switch_delay_ms <= phcc_pkg::SWITCH_DELAY_MS_RST;
			cfg_q.button_divider  <= phcc_pkg::BUTTON_DIVIDER_RST;
		end else if (wr_en) begin
			case (wr_index)
				phcc_pkg::REG_PEDAL_MIN:       cfg_q.pedal_min       <= wr_data[9:0];
				phcc_pkg::REG_RPM_LIMIT:       cfg_q.rpm_limit       <= wr_data[13:0];
				phcc_pkg::REG_STEP_FACTOR:     cfg_q.step_factor     <= wr_data;
				phcc_pkg::REG_SWITCH_DELAY_MS: cfg_q.switch_delay_ms <= wr_data;
				phcc_pkg::REG_BUTTON_DIVIDER:  cfg_q.button_divider  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/phcc_step_logic.sv
module phcc_step_logic (
	input  phcc_pkg::cfg_t         cfg,
	input  phcc_pkg::state_t       cur,
	input  phcc_pkg::tick_item_t   item,
	output phcc_pkg::state_t       nxt,
	output phcc_pkg::result_item_t res
);

	// step size: product scaled down, at least one
	function automatic logic [9:0] step_of(input logic [9:0] v, input logic [15:0] f);
		logic [25:0] prod;
		logic [9:0]  s;
		prod = 26'(v) * 26'(f);
		s = prod[25:16];
		return (s == 10'd0) ? 10'd1 : s;
	endfunction

	function automatic logic [9:0] step_up(input logic [9:0] v, input logic [15:0] f);
		logic [10:0] sum;
		sum = {1'b0, v} + {1'b0, step_of(v, f)};
		return sum[10] ? phcc_pkg::HOLD_MAX : sum[9:0];
	endfunction

	function automatic logic [9:0] step_down(input logic [9:0] v, input logic [15:0] f);
		logic [9:0] s;
		s = step_of(v, f);
		return (s > v) ? 10'd0 : v - s;
	endfunction

	logic [7:0]  cnt;
	logic        sample;
	logic        cruise_1, pending_1;
	logic [9:0]  hold_a_1, hold_b_1;
	logic        drop;
	logic        cruise_2;
	logic [9:0]  hold_a_2, hold_b_2;
	logic        take;
	logic        too_low;
	logic        cruise_3, pending_3;
	logic [9:0]  hold_a_3, hold_b_3;
	logic        toggled;
	logic [31:0] toggle_3;
	logic [31:0] elapsed;
	logic        waiting;
	logic        level_3;

	// button sampling
	always_comb begin
		cnt       = cur.tick_count + 8'd1;
		sample    = !(cnt < cfg.button_divider);
		cruise_1  = cur.cruise_on;
		pending_1 = cur.capture_pending;
		hold_a_1  = cur.hold_a;
		hold_b_1  = cur.hold_b;
		if (sample) begin
			case (phcc_pkg::button_t'(item.button))
				phcc_pkg::BTN_UP: begin
					cruise_1  = 1'b1;
					pending_1 = 1'b1;
				end
				phcc_pkg::BTN_VOL_UP: begin
					hold_a_1 = step_up(cur.hold_a, cfg.step_factor);
					hold_b_1 = step_up(cur.hold_b, cfg.step_factor);
				end
				phcc_pkg::BTN_VOL_DOWN: begin
					hold_a_1 = step_down(cur.hold_a, cfg.step_factor);
					hold_b_1 = step_down(cur.hold_b, cfg.step_factor);
				end
				phcc_pkg::BTN_SOURCE: begin
					cruise_1 = 1'b0;
					hold_a_1 = 10'd0;
					hold_b_1 = 10'd0;
				end
				default: ;
			endcase
		end
	end

	// safety checks
	always_comb begin
		drop = !item.pedal_plugged
			|| (item.car_linked && (item.braking || item.engine_rpm > cfg.rpm_limit))
			|| (!item.car_linked && cur.link_was_up);
		cruise_2 = drop ? 1'b0 : cruise_1;
		hold_a_2 = drop ? 10'd0 : hold_a_1;
		hold_b_2 = drop ? 10'd0 : hold_b_1;
	end

	// pedal capture, a reading under the minimum drops cruise again
	always_comb begin
		take      = cruise_2 && pending_1;
		too_low   = (item.pedal_a < cfg.pedal_min) || (item.pedal_b < cfg.pedal_min);
		cruise_3  = cruise_2;
		pending_3 = pending_1;
		hold_a_3  = hold_a_2;
		hold_b_3  = hold_b_2;
		if (take) begin
			pending_3 = 1'b0;
			cruise_3  = !too_low;
			hold_a_3  = too_low ? 10'd0 : item.pedal_a;
			hold_b_3  = too_low ? 10'd0 : item.pedal_b;
		end
	end

	// switch with delayed turn-on, wrap-safe elapsed time
	always_comb begin
		toggled  = (cruise_3 != cur.last_enable_seen);
		toggle_3 = toggled ? item.now_ms : cur.toggle_time;
		elapsed  = item.now_ms - toggle_3;
		waiting  = cruise_3 && (elapsed < {16'd0, cfg.switch_delay_ms});
		level_3  = waiting ? cur.switch_level : cruise_3;
	end

	// next state and result
	always_comb begin
		nxt.cruise_on        = cruise_3;
		nxt.capture_pending  = pending_3;
		nxt.hold_a           = hold_a_3;
		nxt.hold_b           = hold_b_3;
		nxt.tick_count       = sample ? 8'd0 : cnt;
		nxt.link_was_up      = item.car_linked;
		nxt.last_enable_seen = cruise_3;
		nxt.toggle_time      = toggle_3;
		nxt.switch_level     = level_3;
		nxt.last_duty_a      = hold_a_3;
		nxt.last_duty_b      = hold_b_3;

		res.switch_on    = level_3;
		res.duty_a       = hold_a_3;
		res.duty_b       = hold_b_3;
		res.duty_changed = (hold_a_3 != cur.last_duty_a) || (hold_b_3 != cur.last_duty_b);
		res.cruise_led   = cruise_3;
	end

endmodule

>>> sv/phcc_checker.sv
`include "pedal_hold_cruise_controller_macros.svh"

module phcc_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   tick_ready,
	input logic                   result_valid,
	input logic                   result_ready,
	input phcc_pkg::result_item_t result_data
);

	// stalled result keeps its value
	`PHCC_ASSERT_CLK(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result_data), "stalled result changed")

	// switch only closes while cruise is enabled
	`PHCC_ASSERT_CLK(a_switch_needs_cruise, result_valid && result_data.switch_on |-> result_data.cruise_led, "switch on without cruise")

	// an empty result register never blocks ticks
	`PHCC_ASSERT_CLK(a_ready_when_empty, !result_valid |-> tick_ready, "tick stalled with empty result")

	// no result once reset has been seen
	`PHCC_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !result_valid, "result valid in reset")

endmodule

bind pedal_hold_cruise_controller phcc_checker u_phcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

>>> tb/sv/pedal_hold_cruise_controller_tb.sv
module pedal_hold_cruise_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [phcc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [2:0] BTN_RSVD = 3'd7;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	phcc_tick_if tick_ch();
	phcc_result_if res_ch();
	phcc_cfg_if cfg_ch();

	pedal_hold_cruise_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// shadow of the controller registers and state
	phcc_pkg::cfg_t reg_shadow;
	phcc_pkg::state_t cruise_st;
	phcc_pkg::result_item_t awaited_outputs[$];

	logic [31:0] ms_clock = 32'hFFFF_F000;
	bit no_idle = 1'b0;
	int ticks_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int settings_used = 1;
	int mismatches = 0;
	int stall_cycles = 0;

	// clock
	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// cruise controller model
	// ---------------------------------------------------------------

	task automatic reset_model();
		reg_shadow = '{pedal_min: phcc_pkg::PEDAL_MIN_RST, rpm_limit: phcc_pkg::RPM_LIMIT_RST,
			step_factor: phcc_pkg::STEP_FACTOR_RST,
			switch_delay_ms: phcc_pkg::SWITCH_DELAY_MS_RST,
			button_divider: phcc_pkg::BUTTON_DIVIDER_RST};
		cruise_st = '0;
		cruise_st.last_enable_seen = 1'b1;
		cruise_st.last_duty_a = 10'd1;
		cruise_st.last_duty_b = 10'd1;
	endtask

	function automatic void clear_cruise();
		cruise_st.cruise_on = 1'b0;
		cruise_st.hold_a = '0;
		cruise_st.hold_b = '0;
	endfunction

	// step is v * factor in q0.16, never less than one
	function automatic logic [9:0] hold_step(input logic [9:0] v);
		logic [25:0] prod;
		prod = 26'(v) * 26'(reg_shadow.step_factor);
		return (prod[25:16] == 10'd0) ? 10'd1 : prod[25:16];
	endfunction

	function automatic logic [9:0] hold_raise(input logic [9:0] v);
		logic [10:0] sum;
		sum = {1'b0, v} + {1'b0, hold_step(v)};
		return (sum > {1'b0, phcc_pkg::HOLD_MAX}) ? phcc_pkg::HOLD_MAX : sum[9:0];
	endfunction

	function automatic logic [9:0] hold_lower(input logic [9:0] v);
		logic [9:0] s;
		s = hold_step(v);
		return (s > v) ? 10'd0 : v - s;
	endfunction

	function automatic phcc_pkg::result_item_t predict_cruise_tick(
			input phcc_pkg::tick_item_t t);
		logic [7:0] cnt;
		phcc_pkg::result_item_t r;
		// button sampling every divider ticks
		cnt = cruise_st.tick_count + 8'd1;
		if (cnt < reg_shadow.button_divider) begin
			cruise_st.tick_count = cnt;
		end else begin
			cruise_st.tick_count = '0;
			case (t.button)
				phcc_pkg::BTN_UP: begin
					cruise_st.cruise_on = 1'b1;
					cruise_st.capture_pending = 1'b1;
				end
				phcc_pkg::BTN_VOL_UP: begin
					cruise_st.hold_a = hold_raise(cruise_st.hold_a);
					cruise_st.hold_b = hold_raise(cruise_st.hold_b);
				end
				phcc_pkg::BTN_VOL_DOWN: begin
					cruise_st.hold_a = hold_lower(cruise_st.hold_a);
					cruise_st.hold_b = hold_lower(cruise_st.hold_b);
				end
				phcc_pkg::BTN_SOURCE: clear_cruise();
				default: ;
			endcase
		end
		// safety drops
		if (!t.pedal_plugged)
			clear_cruise();
		if (t.car_linked) begin
			if (t.braking || t.engine_rpm > reg_shadow.rpm_limit)
				clear_cruise();
		end else if (cruise_st.link_was_up) begin
			clear_cruise();
		end
		cruise_st.link_was_up = t.car_linked;
		// pending capture of both readings
		if (cruise_st.cruise_on && cruise_st.capture_pending) begin
			cruise_st.capture_pending = 1'b0;
			cruise_st.hold_a = t.pedal_a;
			cruise_st.hold_b = t.pedal_b;
			if (t.pedal_a < reg_shadow.pedal_min || t.pedal_b < reg_shadow.pedal_min)
				clear_cruise();
		end
		// delayed switch turn-on, wrap-safe difference
		if (cruise_st.cruise_on != cruise_st.last_enable_seen) begin
			cruise_st.last_enable_seen = cruise_st.cruise_on;
			cruise_st.toggle_time = t.now_ms;
		end
		if (!(cruise_st.cruise_on &&
				(t.now_ms - cruise_st.toggle_time) < {16'd0, reg_shadow.switch_delay_ms}))
			cruise_st.switch_level = cruise_st.cruise_on;
		// duty outputs
		r.duty_changed = (cruise_st.hold_a != cruise_st.last_duty_a) ||
			(cruise_st.hold_b != cruise_st.last_duty_b);
		cruise_st.last_duty_a = cruise_st.hold_a;
		cruise_st.last_duty_b = cruise_st.hold_b;
		r.switch_on = cruise_st.switch_level;
		r.duty_a = cruise_st.hold_a;
		r.duty_b = cruise_st.hold_b;
		r.cruise_led = cruise_st.cruise_on;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// tick builders
	// ---------------------------------------------------------------

	// millisecond clock, mostly small steps, sometimes a long jump
	function automatic logic [31:0] next_ms();
		if ($urandom_range(59) == 0)
			ms_clock += $urandom_range(200000);
		else
			ms_clock += $urandom_range(40);
		return ms_clock;
	endfunction

	function automatic phcc_pkg::tick_item_t make_tick(input logic [2:0] btn,
			input logic [9:0] pa, input logic [9:0] pb, input logic plugged,
			input logic linked, input logic brk, input logic [13:0] rpm);
		phcc_pkg::tick_item_t t;
		t.button = btn;
		t.pedal_a = pa;
		t.pedal_b = pb;
		t.pedal_plugged = plugged;
		t.car_linked = linked;
		t.braking = brk;
		t.engine_rpm = rpm;
		t.now_ms = next_ms();
		return t;
	endfunction

	function automatic logic [2:0] pick_button();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 50) return phcc_pkg::BTN_NONE;
		if (p < 62) return phcc_pkg::BTN_UP;
		if (p < 76) return phcc_pkg::BTN_VOL_UP;
		if (p < 90) return phcc_pkg::BTN_VOL_DOWN;
		if (p < 93) return phcc_pkg::BTN_SOURCE;
		if (p < 95) return phcc_pkg::BTN_INFO;
		if (p < 97) return phcc_pkg::BTN_DOWN;
		return BTN_RSVD;
	endfunction

	// plugged, linked, no brake, rpm and readings inside the limits
	function automatic phcc_pkg::tick_item_t healthy_tick(input logic [2:0] btn);
		return make_tick(btn, 10'($urandom_range(1023, reg_shadow.pedal_min)),
			10'($urandom_range(1023, reg_shadow.pedal_min)), 1'b1, 1'b1, 1'b0,
			14'($urandom_range(reg_shadow.rpm_limit, 0)));
	endfunction

	// healthy tick with one drop condition injected
	function automatic phcc_pkg::tick_item_t faulty_tick();
		phcc_pkg::tick_item_t t;
		t = healthy_tick(pick_button());
		case ($urandom_range(4))
			0: t.pedal_plugged = 1'b0;
			1: t.braking = 1'b1;
			2: begin
				if (reg_shadow.rpm_limit != 14'h3FFF)
					t.engine_rpm = 14'($urandom_range(16383, reg_shadow.rpm_limit + 1));
				else
					t.braking = 1'b1;
			end
			3: begin
				t.car_linked = 1'b0;
				t.braking = 1'($urandom_range(1));
			end
			default: begin
				t.button = phcc_pkg::BTN_UP;
				if (reg_shadow.pedal_min != 10'd0)
					t.pedal_b = 10'($urandom_range(reg_shadow.pedal_min - 1, 0));
			end
		endcase
		return t;
	endfunction

	function automatic phcc_pkg::tick_item_t random_tick();
		phcc_pkg::tick_item_t t;
		int unsigned p;
		p = $urandom_range(99);
		if (p < 8) begin
			// noise: every field random
			t = 72'({$urandom, $urandom, $urandom});
			if ($urandom_range(1) == 0)
				t.now_ms = next_ms();
		end else if (p < 15) begin
			t = faulty_tick();
		end else begin
			t = healthy_tick(pick_button());
		end
		return t;
	endfunction

	// ---------------------------------------------------------------
	// channel drivers
	// ---------------------------------------------------------------

	// one tick transaction; returns at the next falling edge with valid still high
	task automatic send_tick(input phcc_pkg::tick_item_t item);
		while (!no_idle && $urandom_range(99) < 22) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data <= item;
		do @(posedge clk); while (!tick_ch.ready);
		awaited_outputs.push_back(predict_cruise_tick(item));
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic wait_outputs_drained();
		tick_ch.valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [phcc_pkg::CFG_IDX_W-1:0] idx,
			input logic [phcc_pkg::CFG_DATA_W-1:0] wd);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= wd;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			phcc_pkg::REG_PEDAL_MIN: reg_shadow.pedal_min = wd[9:0];
			phcc_pkg::REG_RPM_LIMIT: reg_shadow.rpm_limit = wd[13:0];
			phcc_pkg::REG_STEP_FACTOR: reg_shadow.step_factor = wd;
			phcc_pkg::REG_SWITCH_DELAY_MS: reg_shadow.switch_delay_ms = wd;
			phcc_pkg::REG_BUTTON_DIVIDER: reg_shadow.button_divider = wd[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	// full register set, unused upper data bits filled with junk
	task automatic apply_cfg(input phcc_pkg::cfg_t c, input bit poke_unused);
		write_reg(phcc_pkg::REG_PEDAL_MIN, {6'($urandom), c.pedal_min});
		write_reg(phcc_pkg::REG_RPM_LIMIT, {2'($urandom), c.rpm_limit});
		write_reg(phcc_pkg::REG_STEP_FACTOR, c.step_factor);
		write_reg(phcc_pkg::REG_SWITCH_DELAY_MS, c.switch_delay_ms);
		write_reg(phcc_pkg::REG_BUTTON_DIVIDER, {8'($urandom), c.button_divider});
		if (poke_unused)
			write_reg(REG_UNUSED, 16'($urandom));
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_traffic(input int n, input bit pause_midway);
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2)
				wait_outputs_drained();
			send_tick(random_tick());
		end
		wait_outputs_drained();
	endtask

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	// receiver stalls
	always @(negedge clk)
		res_ch.ready <= no_idle || ($urandom_range(99) >= 22);

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_outputs
		phcc_pkg::result_item_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (awaited_outputs.size() == 0) begin
				report_mismatch("unexpected result", 32'(res_ch.data), 32'd0);
			end else begin
				want = awaited_outputs.pop_front();
				if (res_ch.data.switch_on !== want.switch_on)
					report_mismatch("switch_on", 32'(res_ch.data.switch_on),
						32'(want.switch_on));
				if (res_ch.data.duty_a !== want.duty_a)
					report_mismatch("duty_a", 32'(res_ch.data.duty_a), 32'(want.duty_a));
				if (res_ch.data.duty_b !== want.duty_b)
					report_mismatch("duty_b", 32'(res_ch.data.duty_b), 32'(want.duty_b));
				if (res_ch.data.duty_changed !== want.duty_changed)
					report_mismatch("duty_changed", 32'(res_ch.data.duty_changed),
						32'(want.duty_changed));
				if (res_ch.data.cruise_led !== want.cruise_led)
					report_mismatch("cruise_led", 32'(res_ch.data.cruise_led),
						32'(want.cruise_led));
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// register values right after reset
	task automatic test_reset_defaults();
		run_traffic(40, 1'b0);
	endtask

	// field extremes, every button, capture and drop paths
	task automatic test_directed();
		apply_cfg('{pedal_min: 10'd100, rpm_limit: 14'd4000, step_factor: 16'd655,
			switch_delay_ms: 16'd0, button_divider: 8'd1}, 1'b0);
		send_tick('0);
		send_tick('1);
		// volume steps with cruise off, down to zero and past it
		send_tick(make_tick(phcc_pkg::BTN_VOL_UP, 10'd300, 10'd300, 1'b1, 1'b1, 1'b0,
			14'd1000));
		send_tick(make_tick(phcc_pkg::BTN_VOL_DOWN, 10'd300, 10'd300, 1'b1, 1'b1, 1'b0,
			14'd1000));
		send_tick(make_tick(phcc_pkg::BTN_VOL_DOWN, 10'd300, 10'd300, 1'b1, 1'b1, 1'b0,
			14'd1000));
		// capture at full scale, then saturate upward
		send_tick(make_tick(phcc_pkg::BTN_UP, 10'd1023, 10'd1023, 1'b1, 1'b1, 1'b0,
			14'd4000));
		send_tick(make_tick(phcc_pkg::BTN_VOL_UP, 10'd200, 10'd200, 1'b1, 1'b1, 1'b0,
			14'd0));
		// buttons with no effect, then source clearing cruise
		send_tick(make_tick(phcc_pkg::BTN_INFO, 10'd200, 10'd200, 1'b1, 1'b1, 1'b0, 14'd0));
		send_tick(make_tick(phcc_pkg::BTN_DOWN, 10'd200, 10'd200, 1'b1, 1'b1, 1'b0, 14'd0));
		send_tick(make_tick(phcc_pkg::BTN_SOURCE, 10'd200, 10'd200, 1'b1, 1'b1, 1'b0,
			14'd0));
		// arm while unplugged keeps the capture request
		send_tick(make_tick(phcc_pkg::BTN_UP, 10'd500, 10'd500, 1'b0, 1'b1, 1'b0, 14'd0));
		// capture below the minimum reading
		send_tick(make_tick(phcc_pkg::BTN_UP, 10'd50, 10'd600, 1'b1, 1'b1, 1'b0, 14'd0));
		// brake, rpm over limit and lost link each drop cruise
		send_tick(make_tick(phcc_pkg::BTN_UP, 10'd400, 10'd700, 1'b1, 1'b1, 1'b0, 14'd0));
		send_tick(make_tick(phcc_pkg::BTN_NONE, 10'd400, 10'd700, 1'b1, 1'b1, 1'b1, 14'd0));
		send_tick(make_tick(phcc_pkg::BTN_UP, 10'd400, 10'd700, 1'b1, 1'b1, 1'b0, 14'd0));
		send_tick(make_tick(phcc_pkg::BTN_NONE, 10'd400, 10'd700, 1'b1, 1'b1, 1'b0,
			14'd4001));
		send_tick(make_tick(phcc_pkg::BTN_UP, 10'd400, 10'd700, 1'b1, 1'b1, 1'b0, 14'd0));
		send_tick(make_tick(phcc_pkg::BTN_NONE, 10'd400, 10'd700, 1'b1, 1'b0, 1'b1,
			14'd9000));
		wait_outputs_drained();
	endtask

	// divider lowered under the running count, and a divider of zero
	task automatic test_divider_edges();
		apply_cfg('{pedal_min: 10'd100, rpm_limit: 14'd4000, step_factor: 16'd655,
			switch_delay_ms: 16'd0, button_divider: 8'd200}, 1'b1);
		repeat (4) send_tick(healthy_tick(phcc_pkg::BTN_UP));
		wait_outputs_drained();
		apply_cfg('{pedal_min: 10'd100, rpm_limit: 14'd4000, step_factor: 16'd655,
			switch_delay_ms: 16'd0, button_divider: 8'd2}, 1'b0);
		send_tick(healthy_tick(phcc_pkg::BTN_UP));
		send_tick(healthy_tick(phcc_pkg::BTN_VOL_UP));
		send_tick(healthy_tick(phcc_pkg::BTN_VOL_UP));
		wait_outputs_drained();
		apply_cfg('{pedal_min: 10'd100, rpm_limit: 14'd4000, step_factor: 16'd655,
			switch_delay_ms: 16'd0, button_divider: 8'd0}, 1'b0);
		send_tick(healthy_tick(phcc_pkg::BTN_VOL_DOWN));
		send_tick(healthy_tick(phcc_pkg::BTN_SOURCE));
		wait_outputs_drained();
	endtask

	// back-to-back transactions on both sides
	task automatic test_steady_stream();
		apply_cfg('{pedal_min: 10'd100, rpm_limit: 14'd4000, step_factor: 16'd655,
			switch_delay_ms: 16'd300, button_divider: 8'd1}, 1'b0);
		no_idle = 1'b1;
		run_traffic(250, 1'b0);
		no_idle = 1'b0;
	endtask

	// register extremes
	task automatic test_extreme_settings();
		apply_cfg('{pedal_min: 10'd0, rpm_limit: 14'h3FFF, step_factor: 16'hFFFF,
			switch_delay_ms: 16'd0, button_divider: 8'd2}, 1'b0);
		run_traffic(200, 1'b0);
		apply_cfg('{pedal_min: 10'h3FF, rpm_limit: 14'd0, step_factor: 16'd0,
			switch_delay_ms: 16'hFFFF, button_divider: 8'd1}, 1'b0);
		run_traffic(120, 1'b0);
	endtask

	// sender holds off until every result is back, then resumes
	task automatic test_paused_sender();
		apply_cfg('{pedal_min: 10'd512, rpm_limit: 14'd8000, step_factor: 16'd20000,
			switch_delay_ms: 16'd1000, button_divider: 8'd3}, 1'b0);
		run_traffic(220, 1'b1);
	endtask

	task automatic test_random_settings();
		apply_cfg('{pedal_min: 10'($urandom_range(600)),
			rpm_limit: 14'($urandom_range(16383, 1000)), step_factor: 16'($urandom),
			switch_delay_ms: 16'($urandom_range(2000)),
			button_divider: 8'($urandom_range(4, 1))}, 1'b0);
		run_traffic(180, 1'b0);
	endtask

	// largest divider, buttons almost never sampled
	task automatic test_slow_buttons();
		apply_cfg('{pedal_min: 10'd1, rpm_limit: 14'd1, step_factor: 16'd1,
			switch_delay_ms: 16'd200, button_divider: 8'd255}, 1'b0);
		run_traffic(80, 1'b0);
	endtask

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_directed();
		test_divider_edges();
		test_steady_stream();
		test_extreme_settings();
		test_paused_sender();
		test_random_settings();
		test_slow_buttons();

		// let any stray result show up
		repeat (6) @(posedge clk);
		$display("covered %0d ticks and %0d results under %0d register settings",
			ticks_sent, results_seen, settings_used);
		$display("%0d register writes, %0d mismatches", reg_writes, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/phcc_pkg.sv
sv/phcc_ifs.sv
sv/phcc_cfg_regs.sv
sv/phcc_step_logic.sv
sv/pedal_hold_cruise_controller.sv
sv/phcc_checker.sv
tb/sv/pedal_hold_cruise_controller_tb.sv
